/* rtl/lfucr_pkg.sv */
// Shared types and constants of the LFU cache directory.
`timescale 1ns / 1ps

package lfucr_pkg;

   localparam int KEY_W    = 32;
   localparam int CNT_W    = 32;
   localparam int STAMP_W  = 32;
   localparam int CAP_W    = 7;
   localparam int OCC_W    = 7;
   localparam int REQ_W    = 32;
   localparam int TDATA_W  = 104;
   localparam int TUSER_W  = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // One directory entry as held in the entry memory.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [CNT_W-1:0]   count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;    // capture the key and restart the scan
      logic scan;     // issue entry reads while entries remain
      logic commit;   // write the entry back and load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } dp_status_type;

   // One result beat.
   typedef struct packed {
      logic               was_hit;
      logic               did_evict;
      logic [KEY_W-1:0]   victim_key;
      logic [CNT_W-1:0]   use_count;
      logic [CNT_W-1:0]   total_hits;
      logic [OCC_W-1:0]   occupancy;
   } result_type;

endpackage

/* rtl/lfucr_ctrl.sv */
// Controller state machine of the LFU cache directory.
`timescale 1ns / 1ps

module lfucr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  lfucr_pkg::dp_status_type status,
   output lfucr_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_tvalid_ff;
   logic      rsp_free;

   // The result register can take a new beat when empty or being drained.
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd.start  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_COMMIT) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/lfucr_dpath.sv */
// Datapath of the LFU cache directory: entry memory, scan and update logic.
`timescale 1ns / 1ps

module lfucr_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lfucr_pkg::ctrl_cmd_type             cmd,
   output lfucr_pkg::dp_status_type            status,
   input  logic [lfucr_pkg::KEY_W-1:0]         req_key,
   input  logic                                csr_we,
   input  logic [lfucr_pkg::CAP_W-1:0]         csr_data,
   output lfucr_pkg::result_type               result
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Valid entries always occupy the slots below the fill count, since an
   // eviction refills the freed slot at once.
   lfucr_pkg::entry_type entry_mem [DEPTH];

   logic [lfucr_pkg::CAP_W-1:0]   capacity_ff;
   logic [lfucr_pkg::STAMP_W-1:0] seq_ff, seq_in;
   logic [lfucr_pkg::CNT_W-1:0]   hits_ff, hits_in;
   logic [CW-1:0]                 used_ff, used_in;
   logic [lfucr_pkg::KEY_W-1:0]   key_ff;

   logic [CW-1:0]                 rd_addr_ff, rd_addr_in;
   logic                          rd_pend_ff;
   logic [AW-1:0]                 rd_idx_ff;
   lfucr_pkg::entry_type          rd_data_ff;
   logic                          issue;

   logic                          match_ff, match_in;
   logic [AW-1:0]                 match_idx_ff, match_idx_in;
   logic [lfucr_pkg::CNT_W-1:0]   match_cnt_ff, match_cnt_in;

   logic                          best_ff, best_in;
   logic [AW-1:0]                 best_idx_ff, best_idx_in;
   logic [lfucr_pkg::CNT_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [lfucr_pkg::STAMP_W-1:0] best_age_ff, best_age_in;
   logic [lfucr_pkg::KEY_W-1:0]   best_key_ff, best_key_in;

   logic [lfucr_pkg::STAMP_W-1:0] cur_age;
   logic [CW-1:0]                 eff_cap;
   logic                          evict;
   logic                          wr_en;
   logic [AW-1:0]                 wr_idx;
   lfucr_pkg::entry_type          wr_entry;
   logic [lfucr_pkg::CNT_W-1:0]   hit_cnt;
   lfucr_pkg::result_type         result_ff, result_in;

   assign issue            = cmd.scan && (rd_addr_ff < used_ff);
   assign rd_addr_in       = issue ? rd_addr_ff + CW'(1) : rd_addr_ff;
   assign status.scan_done = (rd_addr_ff == used_ff) && !rd_pend_ff;
   assign cur_age          = seq_ff - rd_data_ff.stamp;
   assign result           = result_ff;

   // Capacity zero acts as one, capacity above the depth as the depth.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CW'(1);
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(capacity_ff);
      end
   end

   // Scan: first key match, and the entry with the lowest count and the
   // greatest age; strict compares keep the lowest slot on an exact tie.
   always_comb begin
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_cnt_in = match_cnt_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_cnt_in  = best_cnt_ff;
      best_age_in  = best_age_ff;
      best_key_in  = best_key_ff;
      if (rd_pend_ff) begin
         if (!match_ff && (rd_data_ff.key == key_ff)) begin
            match_in     = 1'b1;
            match_idx_in = rd_idx_ff;
            match_cnt_in = rd_data_ff.count;
         end
         if (!best_ff || (rd_data_ff.count < best_cnt_ff) ||
             ((rd_data_ff.count == best_cnt_ff) && (cur_age > best_age_ff))) begin
            best_in     = 1'b1;
            best_idx_in = rd_idx_ff;
            best_cnt_in = rd_data_ff.count;
            best_age_in = cur_age;
            best_key_in = rd_data_ff.key;
         end
      end
   end

   // Update of the accessed entry and the running totals.
   always_comb begin
      evict   = !match_ff && (used_ff >= eff_cap) && best_ff;
      hit_cnt = (match_cnt_ff == lfucr_pkg::COUNT_MAX) ? match_cnt_ff
                                                      : match_cnt_ff + 1'b1;
      seq_in  = seq_ff + 1'b1;
      hits_in = hits_ff;
      used_in = used_ff;
      wr_entry.key   = key_ff;
      wr_entry.stamp = seq_ff;
      if (match_ff) begin
         // A saturated count is not reached again, so its stamp stays.
         wr_en          = (match_cnt_ff != lfucr_pkg::COUNT_MAX);
         wr_idx         = match_idx_ff;
         wr_entry.count = hit_cnt;
         hits_in        = hits_ff + 1'b1;
      end else begin
         wr_en          = 1'b1;
         wr_idx         = evict ? best_idx_ff : used_ff[AW-1:0];
         wr_entry.count = lfucr_pkg::COUNT_ONE;
         if (!evict) begin
            used_in = used_ff + CW'(1);
         end
      end
      result_in.was_hit    = match_ff;
      result_in.did_evict  = evict;
      result_in.victim_key = evict ? best_key_ff : '0;
      result_in.use_count  = match_ff ? hit_cnt : lfucr_pkg::COUNT_ONE;
      result_in.total_hits = hits_in;
      result_in.occupancy  = lfucr_pkg::OCC_W'(used_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
      if (issue) begin
         rd_data_ff <= entry_mem[rd_addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfucr_pkg::CAP_RESET;
         seq_ff      <= '0;
         hits_ff     <= '0;
         used_ff     <= '0;
         rd_addr_ff  <= '0;
         rd_pend_ff  <= 1'b0;
         match_ff    <= 1'b0;
         best_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_data;
         end
         if (cmd.start) begin
            rd_addr_ff <= '0;
            rd_pend_ff <= 1'b0;
            match_ff   <= 1'b0;
            best_ff    <= 1'b0;
         end else begin
            rd_addr_ff <= rd_addr_in;
            rd_pend_ff <= issue;
            match_ff   <= match_in;
            best_ff    <= best_in;
         end
         if (cmd.commit) begin
            seq_ff  <= seq_in;
            hits_ff <= hits_in;
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_key;
      end
      rd_idx_ff    <= rd_addr_ff[AW-1:0];
      match_idx_ff <= match_idx_in;
      match_cnt_ff <= match_cnt_in;
      best_idx_ff  <= best_idx_in;
      best_cnt_ff  <= best_cnt_in;
      best_age_ff  <= best_age_in;
      best_key_ff  <= best_key_in;
      if (cmd.commit) begin
         result_ff <= result_in;
      end
   end

endmodule

/* rtl/lfu_cache_replacement_top.sv */
// Top level of the LFU cache directory with least-recently-reached tie-break.
//
// Usage: each beat on the req channel carries one signed 32-bit key. The block
// looks the key up in its directory. On a hit the entry's use count goes up by
// one (saturating) and the hit total goes up. On a miss with the directory at
// capacity, the entry with the lowest count is evicted, ties going to the
// entry that reached its count earliest, then the lowest slot; the new key is
// inserted with count one. One result beat per request leaves on rsp.
// Timing: the entries sit in a single-port memory that is scanned one entry a
// cycle. A request is accepted only while idle; the scan then reads each held
// entry, and the commit writes the accessed entry back, loads the result
// register and returns to idle, where the next request is accepted.
// The csr channel writes the capacity register and is always ready; the user
// must write it only while no request is in flight, as the block does not enforce it.
// Reset empties the directory and clears the hit total and access sequence;
// capacity returns to 64. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and worked on, and waits only for its write-back.
`timescale 1ns / 1ps

module lfu_cache_replacement_top #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel; tdata: access_key[31:0].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lfucr_pkg::REQ_W-1:0]     req_tdata,
   // Result channel; tdata: victim_key[31:0], use_count[63:32],
   // total_hits[95:64], occupancy[102:96], zero pad[103].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lfucr_pkg::TDATA_W-1:0]   rsp_tdata,
   // tuser: was_hit[0], did_evict[1].
   output logic [lfucr_pkg::TUSER_W-1:0]   rsp_tuser,
   // Capacity register write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfucr_pkg::CAP_W-1:0]     csr_data
);

   lfucr_pkg::ctrl_cmd_type  cmd;
   lfucr_pkg::dp_status_type status;
   lfucr_pkg::result_type    result;

   // Configuration is taken in any cycle.
   assign csr_ready = 1'b1;

   lfucr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfucr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_key  (req_tdata),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .result   (result)
   );

   // Pack the result beat, first field in the lowest bits.
   assign rsp_tdata = {1'b0, result.occupancy, result.total_hits,
                       result.use_count, result.victim_key};
   assign rsp_tuser = {result.did_evict, result.was_hit};

endmodule

/* rtl/lfucr_checker.sv */
// Port-level checker of the LFU cache directory and its bind.
`timescale 1ns / 1ps

module lfucr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lfucr_pkg::TDATA_W-1:0]   rsp_tdata,
   input logic [lfucr_pkg::TUSER_W-1:0]   rsp_tuser
);

   // A pending result beat stays until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped before it was taken");

   // One request is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // An eviction happens only on a miss.
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("eviction reported on a hit");

   // An inserted key starts with a use count of one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[63:32] == 32'd1)
      else $error("inserted key does not have count one");

   // The victim key reads as zero when nothing was evicted.
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[31:0] == 32'd0)
      else $error("victim key set without an eviction");

endmodule

bind lfu_cache_replacement_top lfucr_checker u_lfucr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* bench/lfu_cache_checker.sv */
// Checker for the LFU cache directory: predicts each response beat and compares it.
`timescale 1ns / 1ps

module lfu_cache_checker #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lfucr_pkg::REQ_W-1:0]     req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lfucr_pkg::TDATA_W-1:0]   rsp_tdata,
   input  logic [lfucr_pkg::TUSER_W-1:0]   rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [lfucr_pkg::CAP_W-1:0]     csr_data,
   output int                              error_count,
   output int                              pending
);

   // Shadow copy of the directory.
   logic                               dir_valid [DEPTH];
   logic [lfucr_pkg::KEY_W-1:0]        dir_key   [DEPTH];
   logic [lfucr_pkg::CNT_W-1:0]        dir_count [DEPTH];
   logic [lfucr_pkg::STAMP_W-1:0]      dir_stamp [DEPTH];
   logic [lfucr_pkg::STAMP_W-1:0]      seq_now;
   logic [lfucr_pkg::CNT_W-1:0]        hits_so_far;
   int                                 slots_used;
   logic [lfucr_pkg::CAP_W-1:0]        capacity_reg;

   lfucr_pkg::result_type              outcome_q [$];
   int                                 beat_index;

   function automatic int effective_capacity();
      int c;
      c = int'(capacity_reg);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   // Lowest count wins; among equal counts the greatest age, then the lowest slot.
   function automatic int choose_victim();
      int best;
      logic [lfucr_pkg::CNT_W-1:0] best_cnt;
      logic [lfucr_pkg::STAMP_W-1:0] best_age;
      logic [lfucr_pkg::STAMP_W-1:0] age;
      best = -1;
      best_cnt = '0;
      best_age = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (dir_valid[i]) begin
            age = seq_now - dir_stamp[i];
            if (best < 0 || dir_count[i] < best_cnt ||
                (dir_count[i] == best_cnt && age > best_age)) begin
               best = i;
               best_cnt = dir_count[i];
               best_age = age;
            end
         end
      end
      return best;
   endfunction

   task automatic predict_access(input logic [lfucr_pkg::KEY_W-1:0] key);
      lfucr_pkg::result_type want;
      int slot;
      int victim_slot;
      want = '0;
      slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (slot < 0 && dir_valid[i] && dir_key[i] == key) slot = i;
      end
      if (slot >= 0) begin
         want.was_hit = 1'b1;
         hits_so_far = hits_so_far + 1'b1;
         // A saturated count is not reached again, so its stamp stays.
         if (dir_count[slot] != lfucr_pkg::COUNT_MAX) begin
            dir_count[slot] = dir_count[slot] + 1'b1;
            dir_stamp[slot] = seq_now;
         end
         want.use_count = dir_count[slot];
      end else begin
         if (slots_used >= effective_capacity()) begin
            victim_slot = choose_victim();
            if (victim_slot >= 0) begin
               want.did_evict = 1'b1;
               want.victim_key = dir_key[victim_slot];
               dir_valid[victim_slot] = 1'b0;
               slots_used--;
               slot = victim_slot;
            end
         end
         if (slot < 0) begin
            for (int i = DEPTH - 1; i >= 0; i--) begin
               if (!dir_valid[i]) slot = i;
            end
         end
         if (slot >= 0) begin
            dir_valid[slot] = 1'b1;
            dir_key[slot] = key;
            dir_count[slot] = lfucr_pkg::COUNT_ONE;
            dir_stamp[slot] = seq_now;
            slots_used++;
         end
         want.use_count = lfucr_pkg::COUNT_ONE;
      end
      seq_now = seq_now + 1'b1;
      want.total_hits = hits_so_far;
      want.occupancy = lfucr_pkg::OCC_W'(slots_used);
      outcome_q.push_back(want);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%t mismatch on result beat %0d, %s: got %h, expected %h",
               $realtime, beat_index, what, got, want);
      error_count++;
   endtask

   task automatic check_result();
      lfucr_pkg::result_type want;
      if (outcome_q.size() == 0) begin
         report_mismatch("unexpected beat", rsp_tdata[31:0], '0);
      end else begin
         want = outcome_q.pop_front();
         if (rsp_tuser[0] !== want.was_hit)
            report_mismatch("was_hit", 32'(rsp_tuser[0]), 32'(want.was_hit));
         if (rsp_tuser[1] !== want.did_evict)
            report_mismatch("did_evict", 32'(rsp_tuser[1]), 32'(want.did_evict));
         if (rsp_tdata[31:0] !== want.victim_key)
            report_mismatch("victim_key", rsp_tdata[31:0], want.victim_key);
         if (rsp_tdata[63:32] !== want.use_count)
            report_mismatch("use_count", rsp_tdata[63:32], want.use_count);
         if (rsp_tdata[95:64] !== want.total_hits)
            report_mismatch("total_hits", rsp_tdata[95:64], want.total_hits);
         if (rsp_tdata[102:96] !== want.occupancy)
            report_mismatch("occupancy", 32'(rsp_tdata[102:96]), 32'(want.occupancy));
      end
      beat_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            dir_valid[i] = 1'b0;
            dir_key[i] = '0;
            dir_count[i] = '0;
            dir_stamp[i] = '0;
         end
         seq_now = '0;
         hits_so_far = '0;
         slots_used = 0;
         capacity_reg = lfucr_pkg::CAP_RESET;
         outcome_q.delete();
         beat_index = 0;
         error_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) capacity_reg = csr_data;
         if (req_tvalid && req_tready) predict_access(req_tdata[lfucr_pkg::KEY_W-1:0]);
      end
      pending = outcome_q.size();
   end

endmodule

/* bench/tb_lfu_cache_replacement_top.sv */
// Testbench top for the LFU cache directory: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_lfu_cache_replacement_top;

   // Longest run of cycles with no beat on any channel before the run is called hung.
   // The limit sits well above HOLD_CYCLES, the long receiver hold-off, and above a
   // full-directory access, so this leaves a wide margin.
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 38;
   localparam int NUM_PHASES  = 12;

   // Keys at the corners of the signed 32-bit range and alternating bit patterns.
   localparam logic [lfucr_pkg::KEY_W-1:0] EDGE_KEYS [9] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
      32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
   };

   // Capacity for each random phase. Zero and values above the depth are
   // included on purpose, as are drops below the current occupancy.
   localparam logic [lfucr_pkg::CAP_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
      7'd1, 7'd4, 7'd64, 7'd100, 7'd8, 7'd0, 7'd16, 7'd3, 7'd127, 7'd32, 7'd2, 7'd48
   };

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [lfucr_pkg::REQ_W-1:0]        req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [lfucr_pkg::TDATA_W-1:0]      rsp_tdata;
   logic [lfucr_pkg::TUSER_W-1:0]      rsp_tuser;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [lfucr_pkg::CAP_W-1:0]        csr_data;

   int                     error_count;
   int                     pending;

   // Pacing knobs of the sender and the receiver. A maximum of zero
   // gives a stretch of back-to-back beats on that side.
   int                     tx_gap_max;
   int                     rx_gap_max;
   bit                     long_hold_req;
   int                     idle_cycles;

   lfu_cache_replacement_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lfu_cache_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The watchdog restarts whenever a beat moves on any channel. If the
   // design hangs, or a response never shows up, the count runs out.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offers one key on the request channel and returns at the edge that
   // accepts it. The valid stays high into the next call when no gap is drawn,
   // so back-to-back beats never see valid dropped and raised in one step.
   task automatic send_key(input logic [lfucr_pkg::KEY_W-1:0] key);
      int gap;
      gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
   endtask

   // Writes the capacity register once every outstanding response has been
   // taken. The first edge lets the checker record any beat accepted in the
   // current step before the outstanding count is trusted.
   task automatic write_capacity(input logic [lfucr_pkg::CAP_W-1:0] cap);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random phase. Most keys come from a small pool sized around the
   // capacity, biased toward its first entries so that some keys climb to
   // high counts while others keep getting evicted. The rest are fully
   // random keys that exercise every bit of the key field.
   task automatic run_mix_phase(input logic [lfucr_pkg::CAP_W-1:0] cap, input bit no_idle,
                                input bit hold_off);
      logic [lfucr_pkg::KEY_W-1:0] key_pool [160];
      int usable;
      int pool_size;
      int pick;
      logic [lfucr_pkg::KEY_W-1:0] key;
      write_capacity(cap);
      usable = (cap == 0) ? 1 : ((cap > 64) ? 64 : int'(cap));
      pool_size = $urandom_range(usable / 2 + 1, usable * 2 + 2);
      if (pool_size > 160) pool_size = 160;
      for (int i = 0; i < pool_size; i++) begin
         key_pool[i] = ($urandom_range(0, 3) == 0) ?
                       lfucr_pkg::KEY_W'($urandom_range(0, 15)) :
                       lfucr_pkg::KEY_W'($urandom());
      end
      tx_gap_max = no_idle ? 0 : 9;
      rx_gap_max = no_idle ? 0 : 9;
      if (hold_off) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, pool_size - 1);
            if ($urandom_range(0, 1) == 1) pick = pick / 2;
            key = key_pool[pick];
         end else begin
            key = lfucr_pkg::KEY_W'($urandom());
         end
         send_key(key);
      end
      req_tvalid <= 1'b0;
   endtask

   // Receiver. Each result beat is preceded by a random stall, and once the
   // main sequence asks for it, by a long hold-off while the sender keeps
   // offering keys, so the output register fills and the input backs up.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
         if (long_hold_req) begin
            stall = HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Main sequence: reset, a short directed part, then random phases that
   // each start with a new capacity.
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      tx_gap_max    = 9;
      rx_gap_max    = 9;
      long_hold_req = 1'b0;
      idle_cycles   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // At the reset capacity: fill with the corner keys, then hit some of
      // them so the counts differ.
      for (int i = 0; i < 9; i++) send_key(EDGE_KEYS[i]);
      req_tvalid <= 1'b0;

      // Capacity lowered below the occupancy: every miss must evict one
      // victim and the occupancy must hold steady. Among the keys seen once,
      // the earliest one to reach count one goes first.
      write_capacity(7'd2);
      send_key(32'h1234_5678);
      send_key(32'h1234_5678);
      send_key(32'h0000_0000);
      send_key(32'hFEDC_BA98);
      req_tvalid <= 1'b0;

      // A capacity of zero behaves as one, and one above the depth as the depth.
      write_capacity(7'd0);
      send_key(32'h0000_0001);
      send_key(32'h0000_0002);
      req_tvalid <= 1'b0;
      write_capacity(7'd127);
      send_key(32'h0000_0003);
      send_key(32'h0000_0003);
      req_tvalid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         run_mix_phase(PHASE_CAPS[p], (p == 3) || (p == 7), p == 5);
      end

      // Drain: wait for every outstanding response, then give the block a
      // full-directory access time to show any stray beat. The watchdog
      // bounds the wait if responses stop coming.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/lfucr_pkg.sv
rtl/lfucr_ctrl.sv
rtl/lfucr_dpath.sv
rtl/lfu_cache_replacement_top.sv
rtl/lfucr_checker.sv
bench/lfu_cache_checker.sv
bench/tb_lfu_cache_replacement_top.sv
